@@ sv/qte_pkg.sv @@
// ----------------------------------------------------------------------------
// qte_pkg
// Shared types, widths and the arctangent table for the quaternion to Euler
// angle pipeline.
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int COMP_W        = 16;
   localparam int PROD_W        = 2 * COMP_W;
   localparam int E_W           = 35;
   localparam int S_W           = 30;
   localparam int MAG_W         = S_W - 1;
   localparam int SQ_N          = 29;
   localparam int ROOT_W        = 2 * SQ_N - 1;
   localparam int CW            = E_W + 3;
   localparam int ACC_W         = 32;
   localparam int ANG_W         = 16;
   localparam int ATAN_LEN      = 24;
   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_AW       = $clog2(FIFO_DEPTH);

   localparam logic signed [E_W-1:0] ONE_POS = E_W'(1) <<< 28;
   localparam logic signed [E_W-1:0] ONE_NEG = -ONE_POS;
   localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1) << (2 * (SQ_N - 1));

   localparam logic [ACC_W-1:0] QUARTER_TURN = 32'h4000_0000;
   localparam logic [ACC_W-1:0] HALF_TURN    = 32'h8000_0000;
   localparam logic [ACC_W-1:0] THREE_Q_TURN = 32'hC000_0000;
   localparam logic [ACC_W-1:0] ROUND_HALF   = 32'h0000_8000;

   localparam logic [ACC_W-1:0] ATAN_TURN [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   typedef struct packed {
      logic signed [E_W-1:0] e0;
      logic signed [E_W-1:0] e3;
      logic signed [E_W-1:0] e7;
      logic signed [E_W-1:0] e8;
      logic signed [S_W-1:0] sin_arg;
      logic                  clamped;
   } qte_item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qte_fifo_stat_type;

endpackage

@@ sv/qte_front.sv @@
// ----------------------------------------------------------------------------
// qte_front
// Accepts quaternions, forms the direction cosine terms and saturates the
// arcsine argument, then pushes one work item into the queue.
// ----------------------------------------------------------------------------
module qte_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [63:0]               req_tdata,  // comp_x, comp_y, comp_z, comp_w
   input  qte_pkg::qte_fifo_stat_type fifo_stat,
   output logic                      push,
   output qte_pkg::qte_item_type     push_item
);
   import qte_pkg::*;

   logic signed [COMP_W-1:0] cx, cy, cz, cw;
   logic f1_v_ff, f2_v_ff;
   logic f1_ready, f2_ready;
   logic signed [PROD_W-1:0] xx_ff, yy_ff, zz_ff, ww_ff, xy_ff, zw_ff;
   logic signed [PROD_W-1:0] xz_ff, yw_ff, yz_ff, xw_ff;
   logic signed [E_W-1:0] e0_in, e3_in, e6_in, e7_in, e8_in;
   logic signed [E_W-1:0] sat_in;
   logic clamp_in;
   qte_item_type item_ff;

   assign cx = req_tdata[15:0];
   assign cy = req_tdata[31:16];
   assign cz = req_tdata[47:32];
   assign cw = req_tdata[63:48];

   assign f2_ready   = !f2_v_ff || !fifo_stat.full;
   assign f1_ready   = !f1_v_ff || f2_ready;
   assign req_tready = f1_ready;
   assign push       = f2_v_ff && !fifo_stat.full;
   assign push_item  = item_ff;

   always_comb begin
      e0_in = E_W'(xx_ff) - E_W'(yy_ff) - E_W'(zz_ff) + E_W'(ww_ff);
      e3_in = (E_W'(xy_ff) - E_W'(zw_ff)) <<< 1;
      e6_in = (E_W'(xz_ff) + E_W'(yw_ff)) <<< 1;
      e7_in = (E_W'(yz_ff) - E_W'(xw_ff)) <<< 1;
      e8_in = E_W'(zz_ff) + E_W'(ww_ff) - E_W'(xx_ff) - E_W'(yy_ff);
      if (e6_in > ONE_POS) begin
         sat_in   = ONE_POS;
         clamp_in = 1'b1;
      end else if (e6_in < ONE_NEG) begin
         sat_in   = ONE_NEG;
         clamp_in = 1'b1;
      end else begin
         sat_in   = e6_in;
         clamp_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
         f2_v_ff <= 1'b0;
      end else begin
         if (f1_ready) f1_v_ff <= req_tvalid;
         if (f2_ready) f2_v_ff <= f1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (f1_ready && req_tvalid) begin
         xx_ff <= cx * cx;
         yy_ff <= cy * cy;
         zz_ff <= cz * cz;
         ww_ff <= cw * cw;
         xy_ff <= cx * cy;
         zw_ff <= cz * cw;
         xz_ff <= cx * cz;
         yw_ff <= cy * cw;
         yz_ff <= cy * cz;
         xw_ff <= cx * cw;
      end
      if (f2_ready && f1_v_ff) begin
         item_ff.e0      <= e0_in;
         item_ff.e3      <= e3_in;
         item_ff.e7      <= e7_in;
         item_ff.e8      <= e8_in;
         item_ff.sin_arg <= S_W'(sat_in);
         item_ff.clamped <= clamp_in;
      end
   end

endmodule

@@ sv/qte_fifo.sv @@
// ----------------------------------------------------------------------------
// qte_fifo
// Short work queue between the front and the back of the pipeline.
// ----------------------------------------------------------------------------
module qte_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  qte_pkg::qte_item_type      push_item,
   input  logic                       pop,
   output qte_pkg::qte_item_type      pop_item,
   output qte_pkg::qte_fifo_stat_type stat
);
   import qte_pkg::*;

   qte_item_type mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [FIFO_AW:0]   count_ff;

   assign stat.full  = (count_ff == (FIFO_AW+1)'(FIFO_DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_item   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop)      count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_item;
   end

endmodule

@@ sv/qte_back.sv @@
// ----------------------------------------------------------------------------
// qte_back
// Pops work items, takes the cosine through a pipelined square root, then
// runs three vectoring CORDIC pipelines and holds the result register.
// ----------------------------------------------------------------------------
module qte_back (
   input  logic                       clock,
   input  logic                       reset,
   input  qte_pkg::qte_fifo_stat_type fifo_stat,
   input  qte_pkg::qte_item_type      pop_item,
   output logic                       pop,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   output logic [47:0]                rsp_tdata,  // theta_angle, phi_angle, psi_angle
   output logic                       rsp_tuser   // sine_clamped
);
   import qte_pkg::*;

   typedef struct packed {
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] x;
      logic [ACC_W-1:0]     acc;
      logic                 frz;
   } qte_vec_type;

   function automatic qte_vec_type vec_prep(logic signed [CW-1:0] y,
                                            logic signed [CW-1:0] x);
      qte_vec_type v;
      v.y   = y;
      v.x   = x;
      v.acc = '0;
      v.frz = 1'b0;
      if (y == '0) begin
         v.acc = x[CW-1] ? HALF_TURN : '0;
         v.frz = 1'b1;
      end else if (x == '0) begin
         v.acc = y[CW-1] ? THREE_Q_TURN : QUARTER_TURN;
         v.frz = 1'b1;
      end else if (x[CW-1]) begin
         v.y   = -y;
         v.x   = -x;
         v.acc = HALF_TURN;
      end
      return v;
   endfunction

   function automatic qte_vec_type vec_step(qte_vec_type v, int k);
      qte_vec_type n;
      logic signed [CW-1:0] dx, dy;
      n  = v;
      dx = v.y >>> k;
      dy = v.x >>> k;
      if (!v.frz) begin
         if (!v.y[CW-1]) begin
            n.x   = v.x + dx;
            n.y   = v.y - dy;
            n.acc = v.acc + ATAN_TURN[k];
         end else begin
            n.x   = v.x - dx;
            n.y   = v.y + dy;
            n.acc = v.acc - ATAN_TURN[k];
         end
      end
      return n;
   endfunction

   function automatic logic [ANG_W-1:0] to_bam(logic [ACC_W-1:0] acc);
      logic [ACC_W-1:0] r;
      r = acc + ROUND_HALF;
      return r[ACC_W-1:ACC_W-ANG_W];
   endfunction

   logic adv;
   logic [MAG_W-1:0]     mag;
   logic [2*MAG_W-1:0]   sq;
   logic                 sq_v_ff   [SQ_N+1];
   qte_item_type         sq_item_ff[SQ_N+1];
   logic [ROOT_W-1:0]    rem_ff    [SQ_N+1];
   logic [ROOT_W-1:0]    root_ff   [SQ_N+1];
   logic                 cv_v_ff   [CORDIC_STAGES+1];
   logic                 cv_clamp_ff[CORDIC_STAGES+1];
   qte_vec_type          cv_ff     [CORDIC_STAGES+1][3];
   logic                 out_v_ff;
   logic [47:0]          out_data_ff;
   logic                 out_user_ff;
   qte_item_type         last_item;

   assign adv        = !out_v_ff || rsp_tready;
   assign pop        = adv && !fifo_stat.empty;
   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;
   assign last_item  = sq_item_ff[SQ_N];

   assign mag = pop_item.sin_arg[S_W-1] ? MAG_W'(-pop_item.sin_arg) : MAG_W'(pop_item.sin_arg);
   assign sq  = mag * mag;

   always_ff @(posedge clock) begin
      if (reset) sq_v_ff[0] <= 1'b0;
      else if (adv) sq_v_ff[0] <= pop;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sq_item_ff[0] <= pop_item;
         rem_ff[0]     <= ROOT_ONE - ROOT_W'(sq);
         root_ff[0]    <= '0;
      end
   end

   for (genvar j = 1; j <= SQ_N; j++) begin : g_sqrt
      localparam logic [ROOT_W-1:0] BIT = ROOT_W'(1) << (2 * (SQ_N - j));
      logic [ROOT_W-1:0] trial;
      assign trial = root_ff[j-1] + BIT;

      always_ff @(posedge clock) begin
         if (reset) sq_v_ff[j] <= 1'b0;
         else if (adv) sq_v_ff[j] <= sq_v_ff[j-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_item_ff[j] <= sq_item_ff[j-1];
            if (rem_ff[j-1] >= trial) begin
               rem_ff[j]  <= rem_ff[j-1] - trial;
               root_ff[j] <= (root_ff[j-1] >> 1) + BIT;
            end else begin
               rem_ff[j]  <= rem_ff[j-1];
               root_ff[j] <= root_ff[j-1] >> 1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) cv_v_ff[0] <= 1'b0;
      else if (adv) cv_v_ff[0] <= sq_v_ff[SQ_N];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cv_clamp_ff[0] <= last_item.clamped;
         cv_ff[0][0]    <= vec_prep(CW'(last_item.sin_arg), CW'(root_ff[SQ_N]));
         cv_ff[0][1]    <= vec_prep(-CW'(last_item.e7), CW'(last_item.e8));
         cv_ff[0][2]    <= vec_prep(-CW'(last_item.e3), CW'(last_item.e0));
      end
   end

   for (genvar k = 1; k <= CORDIC_STAGES; k++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (reset) cv_v_ff[k] <= 1'b0;
         else if (adv) cv_v_ff[k] <= cv_v_ff[k-1];
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            cv_clamp_ff[k] <= cv_clamp_ff[k-1];
            for (int a = 0; a < 3; a++) begin
               cv_ff[k][a] <= vec_step(cv_ff[k-1][a], k - 1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (adv) out_v_ff <= cv_v_ff[CORDIC_STAGES];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {to_bam(cv_ff[CORDIC_STAGES][2].acc),
                         to_bam(cv_ff[CORDIC_STAGES][1].acc),
                         to_bam(cv_ff[CORDIC_STAGES][0].acc)};
         out_user_ff <= cv_clamp_ff[CORDIC_STAGES];
      end
   end

endmodule

@@ sv/quaternion_to_euler_angles.sv @@
// throughput: one quaternion per cycle while rsp_tready is high, set by the fully
// pipelined square root and cordic
// a four-entry queue lets the front keep taking transfers while the result side stalls
// reset: synchronous, active high; clears all valid flags and the queue, payload is not reset
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Converts a Q2.14 quaternion stream into three binary-angle Euler angles.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // comp_x, comp_y, comp_z, comp_w
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // theta_angle, phi_angle, psi_angle
   output logic        rsp_tuser    // sine_clamped
);
   import qte_pkg::*;

   qte_fifo_stat_type fifo_stat;
   qte_item_type      push_item, pop_item;
   logic              push, pop;

   qte_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .fifo_stat  (fifo_stat),
      .push       (push),
      .push_item  (push_item)
   );

   qte_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .pop_item  (pop_item),
      .stat      (fifo_stat)
   );

   qte_back u_back (
      .clock      (clock),
      .reset      (reset),
      .fifo_stat  (fifo_stat),
      .pop_item   (pop_item),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

@@ sv/qte_checker.sv @@
// ----------------------------------------------------------------------------
// qte_checker
// Port-level checks on the result stream of the Euler angle converter.
// ----------------------------------------------------------------------------
module qte_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tuser
);

   logic in_xfer;
   assign in_xfer = req_tvalid && req_tready && (req_tdata == req_tdata);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   a_clamp_quarter: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[15:0] == 16'h4000 || rsp_tdata[15:0] == 16'hC000)
      else $error("saturated sine without quarter-turn theta");

   a_theta_range: assert property (@(posedge clock) disable iff (reset || in_xfer === 1'bx)
      rsp_tvalid |-> $signed(rsp_tdata[15:0]) >= -16'sd16384
                  && $signed(rsp_tdata[15:0]) <= 16'sd16384)
      else $error("theta outside a quarter turn");

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (.*);

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stream testbench for quaternion_to_euler_angles: drives quaternions with
// random gaps (none in the back-to-back test), predicts the three binary angles and the clamp flag with an
// independent cordic model, and checks every result transfer in order.
// ----------------------------------------------------------------------------
module tb;
   import qte_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 80;

   typedef struct packed {
      logic       clamped;
      logic [15:0] psi;
      logic [15:0] phi;
      logic [15:0] theta;
   } angle_set_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        rsp_tuser;

   angle_set_type expected_angles[$];
   int  failures = 0;
   int  idle_cycles = 0;
   bit  no_gaps = 1'b0;

   quaternion_to_euler_angles DUT (.*);

   always #10 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic logic [31:0] cordic_angle(longint y, longint x);
      logic [31:0] acc;
      longint dx, dy;
      acc = 32'h0;
      if (y == 0) return (x < 0) ? HALF_TURN : 32'h0;
      if (x == 0) return (y > 0) ? QUARTER_TURN : THREE_Q_TURN;
      if (x < 0) begin
         x = -x;
         y = -y;
         acc = HALF_TURN;
      end
      for (int k = 0; k < CORDIC_STAGES && k < ATAN_LEN; k++) begin
         dx = floor_shift(y, k);
         dy = floor_shift(x, k);
         if (y >= 0) begin
            x += dx;
            y -= dy;
            acc += ATAN_TURN[k];
         end else begin
            x -= dx;
            y += dy;
            acc -= ATAN_TURN[k];
         end
      end
      return acc;
   endfunction

   function automatic logic [15:0] to_binary_angle(logic [31:0] acc);
      logic [31:0] r;
      r = acc + ROUND_HALF;
      return r[31:16];
   endfunction

   function automatic angle_set_type euler_angles(logic [63:0] q);
      longint x, y, z, w, e0, e3, e6, e7, e8, s;
      longint unsigned s2, c;
      angle_set_type a;
      x = longint'($signed(q[15:0]));
      y = longint'($signed(q[31:16]));
      z = longint'($signed(q[47:32]));
      w = longint'($signed(q[63:48]));
      e0 = x*x - y*y - z*z + w*w;
      e3 = 2 * (x*y - z*w);
      e6 = 2 * (x*z + y*w);
      e7 = 2 * (y*z - x*w);
      e8 = -(x*x) - y*y + z*z + w*w;
      s = e6;
      a.clamped = 1'b0;
      if (s > (64'sd1 <<< 28)) begin
         s = 64'sd1 <<< 28;
         a.clamped = 1'b1;
      end else if (s < -(64'sd1 <<< 28)) begin
         s = -(64'sd1 <<< 28);
         a.clamped = 1'b1;
      end
      s2 = (s < 0) ? -s : s;
      s2 = s2 * s2;
      c = int_sqrt((64'd1 << 56) - s2);
      a.theta = to_binary_angle(cordic_angle(s, longint'(c)));
      a.phi   = to_binary_angle(cordic_angle(-e7, e8));
      a.psi   = to_binary_angle(cordic_angle(-e3, e0));
      return a;
   endfunction

   task automatic send_quaternion(logic [15:0] x, logic [15:0] y, logic [15:0] z,
                                  logic [15:0] w);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {w, z, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_angles.push_back(euler_angles({w, z, y, x}));
   endtask

   // result side: random stalls per transfer (none while no_gaps is set), checked against the oldest prediction
   initial begin
      int stall;
      angle_set_type got, want;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = no_gaps ? 0 : $urandom_range(0, 11);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         got = {rsp_tuser, rsp_tdata};
         if (expected_angles.size() == 0) begin
            $display("%0t unexpected transfer: actual %h", $time, got);
            failures++;
         end else begin
            want = expected_angles.pop_front();
            if (got.theta !== want.theta) begin
               $display("%0t theta: expected %h actual %h", $time, want.theta, got.theta);
               failures++;
            end
            if (got.phi !== want.phi) begin
               $display("%0t phi: expected %h actual %h", $time, want.phi, got.phi);
               failures++;
            end
            if (got.psi !== want.psi) begin
               $display("%0t psi: expected %h actual %h", $time, want.psi, got.psi);
               failures++;
            end
            if (got.clamped !== want.clamped) begin
               $display("%0t clamp: expected %b actual %b", $time, want.clamped,
                        got.clamped);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[quaternion_to_euler_angles] ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      logic [15:0] corner[6];
      corner = '{16'h0000, 16'h7FFF, 16'h8000, 16'h4000, 16'hC000, 16'h0001};
      send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h0000);
      send_quaternion(16'h0000, 16'h0000, 16'h0000, 16'h4000);
      send_quaternion(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF);
      send_quaternion(16'h8000, 16'h8000, 16'h8000, 16'h8000);
      send_quaternion(16'h2D41, 16'h0000, 16'h2D41, 16'h0000);
      send_quaternion(16'h2D41, 16'h0000, 16'hD2BF, 16'h0000);
      send_quaternion(16'h0000, 16'h4000, 16'h0000, 16'h0000);
      send_quaternion(16'h4000, 16'h0000, 16'h0000, 16'h0000);
      send_quaternion(16'h0000, 16'h0000, 16'h4000, 16'h0000);
      send_quaternion(16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000);
      send_quaternion(16'h7FFF, 16'h0000, 16'h8000, 16'h0000);
      for (int i = 0; i < 12; i++)
         send_quaternion(corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)],
                         corner[$urandom_range(0, 5)], corner[$urandom_range(0, 5)]);
   endtask

   task automatic test_unit_quaternions(int count);
      real a, b, c, d, n;
      for (int i = 0; i < count; i++) begin
         a = $urandom_range(0, 65535) - 32768.0;
         b = $urandom_range(0, 65535) - 32768.0;
         c = $urandom_range(0, 65535) - 32768.0;
         d = $urandom_range(0, 65535) - 32768.0;
         n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
         n = 16384.0 * (0.97 + 0.06 * $urandom_range(0, 1000) / 1000.0) / n;
         send_quaternion(16'($rtoi(a*n)), 16'($rtoi(b*n)), 16'($rtoi(c*n)),
                         16'($rtoi(d*n)));
      end
   endtask

   task automatic test_random_raw(int count);
      for (int i = 0; i < count; i++)
         send_quaternion(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endtask

   task automatic test_back_to_back(int count);
      no_gaps = 1'b1;
      test_unit_quaternions(count);
      no_gaps = 1'b0;
   endtask

   initial begin
      int waited;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_unit_quaternions(700);
      test_back_to_back(150);
      test_random_raw(400);
      req_tvalid <= 1'b0;
      waited = 0;
      while (expected_angles.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_angles.size() == 0)
         $display("[quaternion_to_euler_angles] OK");
      else
         $display("[quaternion_to_euler_angles] ERROR");
      $finish;
   end
endmodule
